// ===== hw/rtl/melody_tone_sequencer_unit_assert.svh =====
// Assertion macros for the melody tone sequencer checkers.
// Included by the checker file; no other dependencies.
`ifndef MELODY_TONE_SEQUENCER_UNIT_ASSERT_SVH
`define MELODY_TONE_SEQUENCER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define MTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("melody tone sequencer check failed");

// Next-cycle implication.
`define MTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("melody tone sequencer check failed");

`endif

// ===== hw/rtl/mts_pkg.sv =====
// Shared types and codes for the melody tone sequencer.
// No dependencies; used by the sequencer module, the checker and the testbench.
package mts_pkg;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    localparam logic [1:0] KIND_TONE = 2'd0;
    localparam logic [1:0] KIND_REST = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;
    localparam logic [1:0] KIND_LOOP = 2'd3;

    localparam logic [16:0] FREQ_MAX    = 17'h1FFFF;
    localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [5:0]  address;
        logic [3:0]  note;
        logic [5:0]  semitones;
        logic [1:0]  kind;
        logic [15:0] duration_ms;
        logic        sound_on;
    } item_t;

    typedef struct packed {
        logic [16:0] tone_freq;
        logic        tone_update;
        logic        finished;
        logic        playing;
    } result_t;

    typedef struct packed {
        logic [3:0]  note;
        logic [5:0]  semitones;
        logic [1:0]  kind;
        logic [15:0] duration;
    } entry_t;

endpackage

// ===== hw/rtl/mts_chan_if.sv =====
// Valid/ready channel carrying one word of a given payload type.
// Depends on nothing; payload types come from mts_pkg at the instance.
interface mts_chan_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/mts_ram.sv =====
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module mts_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;
endmodule

// ===== hw/rtl/mts_tone_calc.sv =====
// Equal-temperament tone frequency: base[note]/16 * 2^(shift/12), Hz with 4 fraction bits.
// Combinational; no package dependencies.
module mts_tone_calc #(
    parameter int MAX_SHIFT = 47
) (
    input  logic [3:0]  note,
    input  logic [5:0]  semitones,
    output logic [16:0] tone
);
    localparam logic [12:0] BASE_FREQ [12] = '{
        13'd4186, 13'd4435, 13'd4699, 13'd4978, 13'd5274, 13'd5588,
        13'd5920, 13'd6272, 13'd6645, 13'd7040, 13'd7459, 13'd7902
    };
    localparam logic [16:0] RATIO_Q16 [12] = '{
        17'd65536, 17'd69433, 17'd73562, 17'd77936, 17'd82570, 17'd87480,
        17'd92682, 17'd98193, 17'd104032, 17'd110218, 17'd116772, 17'd123715
    };
    localparam logic [16:0] FREQ_MAX_L = 17'h1FFFF;

    logic [3:0]  note_sat;
    logic [5:0]  shift;
    logic [2:0]  octave;
    logic [5:0]  octave_base;
    logic [5:0]  rem_wide;
    logic [3:0]  rem;
    logic [29:0] product;
    logic [34:0] scaled;
    logic [34:0] rounded;
    logic [18:0] freq_wide;

    always_comb
    begin
        note_sat = (note > 4'd11) ? 4'd11 : note;
        shift    = (semitones > 6'(MAX_SHIFT)) ? 6'(MAX_SHIFT) : semitones;

        if (shift >= 6'd60)
        begin
            octave = 3'd5;
        end
        else if (shift >= 6'd48)
        begin
            octave = 3'd4;
        end
        else if (shift >= 6'd36)
        begin
            octave = 3'd3;
        end
        else if (shift >= 6'd24)
        begin
            octave = 3'd2;
        end
        else if (shift >= 6'd12)
        begin
            octave = 3'd1;
        end
        else
        begin
            octave = 3'd0;
        end

        octave_base = {octave, 3'b000} + {1'b0, octave, 2'b00};
        rem_wide    = shift - octave_base;
        rem         = rem_wide[3:0];

        product   = 30'(BASE_FREQ[note_sat]) * 30'(RATIO_Q16[rem]);
        scaled    = {5'b0, product} << octave;
        rounded   = scaled + 35'd32768;
        freq_wide = rounded[34:16];
        tone      = (freq_wide > 19'(FREQ_MAX_L)) ? FREQ_MAX_L : freq_wide[16:0];
    end
endmodule

// ===== hw/rtl/melody_tone_sequencer_unit.sv =====
// Melody tone sequencer: table of melody entries, millisecond tick playback.
// A result is in the output register in the cycle after its item is accepted.
// Throughput: one item per cycle while results are taken; the table RAM's registered
// read ports fetch the current and loop-start entries from the next-state addresses, with write bypass.
// Reset clears playback state and the output valid flag, not the output data; table contents are undefined
// until written. Depends on mts_pkg, mts_chan_if, mts_ram, mts_tone_calc.
module melody_tone_sequencer_unit
    import mts_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    parameter int MAX_SHIFT   = 47
) (
    input  logic        clk,
    input  logic        rst_n,
    mts_chan_if.sink    items,
    mts_chan_if.source  results
);
    localparam int AW = $clog2(TABLE_DEPTH);

    logic [AW-1:0] addr_mod [64];

    for (genvar i = 0; i < 64; i++)
    begin : g_addr_mod
        localparam int M = i % TABLE_DEPTH;
        assign addr_mod[i] = AW'(M);
    end

    logic [AW-1:0] pos_reg,    pos_next;
    logic [AW-1:0] start_reg,  start_next;
    logic [16:0]   elapsed_reg, elapsed_next;
    logic [15:0]   dur_reg,    dur_next;
    logic          active_reg, active_next;
    logic [16:0]   tone_reg,   tone_next;
    logic          hit_cur_reg,  hit_cur_next;
    logic          hit_loop_reg, hit_loop_next;
    entry_t        fwd_reg;
    logic          out_valid_reg, out_valid_next;
    result_t       out_data_reg,  out_data_next;

    item_t         item;
    logic          accept;
    logic [AW-1:0] addr_idx;
    logic          we;
    entry_t        wentry;
    logic [27:0]   rdata_cur;
    logic [27:0]   rdata_loop;
    entry_t        cur_entry;
    entry_t        loop_entry;
    entry_t        sel_entry;
    logic [1:0]    sel_kind;
    logic [AW-1:0] sel_pos;
    logic [AW-1:0] sel_pos_inc;
    logic [16:0]   elapsed_inc;
    logic [16:0]   tone_val;
    logic          update;
    logic          finished;

    assign item         = items.data;
    assign accept       = items.valid && items.ready;
    assign items.ready  = !out_valid_reg || results.ready;
    assign results.valid = out_valid_reg;
    assign results.data  = out_data_reg;

    assign addr_idx = addr_mod[item.address];
    assign we       = accept && (item.cmd == CMD_WRITE);
    assign wentry   = '{note: item.note, semitones: item.semitones, kind: item.kind,
                        duration: item.duration_ms};

    mts_ram #(
        .WIDTH (28),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .we      (we),
        .waddr   (addr_idx),
        .wdata   (wentry),
        .raddr_a (pos_next),
        .rdata_a (rdata_cur),
        .raddr_b (start_next),
        .rdata_b (rdata_loop)
    );

    assign cur_entry  = hit_cur_reg  ? fwd_reg : entry_t'(rdata_cur);
    assign loop_entry = hit_loop_reg ? fwd_reg : entry_t'(rdata_loop);

    always_comb
    begin
        if (cur_entry.kind == KIND_LOOP)
        begin
            sel_entry = loop_entry;
            sel_pos   = start_reg;
            sel_kind  = (loop_entry.kind == KIND_LOOP) ? KIND_END : loop_entry.kind;
        end
        else
        begin
            sel_entry = cur_entry;
            sel_pos   = pos_reg;
            sel_kind  = cur_entry.kind;
        end
        sel_pos_inc = (sel_pos == AW'(TABLE_DEPTH - 1)) ? '0 : sel_pos + 1'b1;
    end

    mts_tone_calc #(
        .MAX_SHIFT (MAX_SHIFT)
    ) u_tone (
        .note      (sel_entry.note),
        .semitones (sel_entry.semitones),
        .tone      (tone_val)
    );

    assign elapsed_inc = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg : elapsed_reg + 1'b1;

    always_comb
    begin
        pos_next     = pos_reg;
        start_next   = start_reg;
        elapsed_next = elapsed_reg;
        dur_next     = dur_reg;
        active_next  = active_reg;
        tone_next    = tone_reg;
        update       = 1'b0;
        finished     = 1'b0;

        if (accept)
        begin
            case (item.cmd)
                CMD_START:
                begin
                    start_next  = addr_idx;
                    pos_next    = addr_idx;
                    active_next = 1'b1;
                end
                CMD_TICK:
                begin
                    elapsed_next = elapsed_inc;
                    if (!item.sound_on)
                    begin
                        finished    = active_reg;
                        active_next = 1'b0;
                        tone_next   = '0;
                        update      = 1'b1;
                    end
                    else if (active_reg && (elapsed_inc > {1'b0, dur_reg}))
                    begin
                        update   = 1'b1;
                        pos_next = sel_pos;
                        if (sel_kind == KIND_END)
                        begin
                            tone_next   = '0;
                            active_next = 1'b0;
                            finished    = 1'b1;
                        end
                        else
                        begin
                            tone_next    = (sel_kind == KIND_REST) ? '0 : tone_val;
                            elapsed_next = '0;
                            dur_next     = sel_entry.duration;
                            pos_next     = sel_pos_inc;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        hit_cur_next  = we && (addr_idx == pos_next);
        hit_loop_next = we && (addr_idx == start_next);

        out_data_next = '{tone_freq: tone_next, tone_update: update, finished: finished,
                          playing: active_next};
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            start_reg     <= '0;
            elapsed_reg   <= '0;
            dur_reg       <= '0;
            active_reg    <= 1'b0;
            tone_reg      <= '0;
            hit_cur_reg   <= 1'b0;
            hit_loop_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            start_reg     <= start_next;
            elapsed_reg   <= elapsed_next;
            dur_reg       <= dur_next;
            active_reg    <= active_next;
            tone_reg      <= tone_next;
            hit_cur_reg   <= hit_cur_next;
            hit_loop_reg  <= hit_loop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_reg <= wentry;
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end
endmodule

// ===== hw/rtl/mts_checker.sv =====
// Port-level checks for melody_tone_sequencer_unit, attached by bind.
// Depends on mts_pkg and melody_tone_sequencer_unit_assert.svh.
`include "melody_tone_sequencer_unit_assert.svh"

module mts_checker
    import mts_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [1:0] in_cmd,
    input logic       in_sound_on,
    input logic       out_valid,
    input logic       out_ready,
    input result_t    out_data
);
    `MTS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
    `MTS_ASSERT_NOW(a_fin_idle, clk, rst_n, out_valid && out_data.finished, !out_data.playing && out_data.tone_update && (out_data.tone_freq == 17'd0))
    `MTS_ASSERT_NEXT(a_start_plays, clk, rst_n, in_valid && in_ready && (in_cmd == CMD_START), out_valid && out_data.playing && !out_data.tone_update && !out_data.finished)
    `MTS_ASSERT_NEXT(a_mute_stops, clk, rst_n, in_valid && in_ready && (in_cmd == CMD_TICK) && !in_sound_on, out_valid && out_data.tone_update && !out_data.playing && (out_data.tone_freq == 17'd0))
endmodule

bind melody_tone_sequencer_unit mts_checker u_mts_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (items.valid),
    .in_ready    (items.ready),
    .in_cmd      (items.data.cmd),
    .in_sound_on (items.data.sound_on),
    .out_valid   (results.valid),
    .out_ready   (results.ready),
    .out_data    (results.data)
);

// ===== tb/tb_melody_tone_sequencer_unit.sv =====
// Self-checking testbench for melody_tone_sequencer_unit: directed table, long tick run, random tunes.
// Expected status words come from the directed script or a cycle-free player model in this file.
// Depends on mts_pkg and mts_chan_if from the RTL.
module tb_melody_tone_sequencer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import mts_pkg::*;

    localparam int TABLE_SIZE = 64;
    localparam int SHIFT_CAP = 47;
    localparam int LONG_MS = 20;
    localparam int LONG_RUN_MS = 300;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_WORDS = 260;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam result_t NO_STATUS = '0;

    typedef struct {
        item_t   w;
        bit      typed;
        result_t want;
    } script_row_t;

    logic clk = 1'b0;
    logic rst_n;

    mts_chan_if #(.payload_t(item_t))   items_if ();
    mts_chan_if #(.payload_t(result_t)) results_if ();

    melody_tone_sequencer_unit #(
        .TABLE_DEPTH(TABLE_SIZE),
        .MAX_SHIFT(SHIFT_CAP)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .items(items_if.sink),
        .results(results_if.source)
    );

    int unsigned base_hz [12] = '{4186, 4435, 4699, 4978, 5274, 5588,
                                  5920, 6272, 6645, 7040, 7459, 7902};
    int unsigned ratio_q16 [12] = '{65536, 69433, 73562, 77936, 82570, 87480,
                                    92682, 98193, 104032, 110218, 116772, 123715};

    entry_t      tune_mem [TABLE_SIZE];
    bit          tune_valid [TABLE_SIZE];
    logic [5:0]  play_pos;
    logic [5:0]  loop_addr;
    logic [16:0] elapsed_ms;
    logic [15:0] entry_ms;
    bit          playing_now;
    logic [16:0] tone_now;
    bit          allow_long;

    result_t     status_due [$];
    script_row_t script [$];
    int          errors;
    int          words_sent;
    int          src_idle_pct;
    int          sink_stall_pct;
    int          sink_hold_req;
    int          hold_left;
    int          cycle_count;

    int src_plan [4] = '{0, 82, 0, 32};
    int sink_plan [4] = '{0, 0, 82, 32};

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [16:0] pitch_of(input logic [3:0] note, input logic [5:0] semis);
        logic [3:0]  n;
        logic [5:0]  s;
        logic [63:0] ratio;
        logic [63:0] f;
        n = (note > 4'd11) ? 4'd11 : note;
        s = (semis > 6'(SHIFT_CAP)) ? 6'(SHIFT_CAP) : semis;
        ratio = 64'(ratio_q16[s % 12]) << (s / 12);
        f = (64'(base_hz[n]) * ratio + 64'd32768) >> 16;
        return (f > 64'(FREQ_MAX)) ? FREQ_MAX : f[16:0];
    endfunction

    function automatic result_t player_step(input item_t w);
        result_t r;
        entry_t  e;
        r = '0;
        case (w.cmd)
            CMD_WRITE:
            begin
                tune_mem[w.address] = '{note: w.note, semitones: w.semitones,
                                        kind: w.kind, duration: w.duration_ms};
                tune_valid[w.address] = 1'b1;
            end
            CMD_START:
            begin
                loop_addr = w.address;
                play_pos = w.address;
                playing_now = 1'b1;
            end
            CMD_TICK:
            begin
                if (elapsed_ms != ELAPSED_MAX)
                    elapsed_ms = elapsed_ms + 17'd1;
                if (!w.sound_on)
                begin
                    r.finished = playing_now;
                    playing_now = 1'b0;
                    tone_now = '0;
                    r.tone_update = 1'b1;
                end
                else if (playing_now && elapsed_ms > {1'b0, entry_ms})
                begin
                    e = tune_mem[play_pos];
                    if (e.kind == KIND_LOOP)
                    begin
                        play_pos = loop_addr;
                        e = tune_mem[play_pos];
                        if (e.kind == KIND_LOOP)
                            e.kind = KIND_END;
                    end
                    r.tone_update = 1'b1;
                    if (e.kind == KIND_END)
                    begin
                        tone_now = '0;
                        playing_now = 1'b0;
                        r.finished = 1'b1;
                    end
                    else
                    begin
                        tone_now = (e.kind == KIND_REST) ? 17'd0 : pitch_of(e.note, e.semitones);
                        elapsed_ms = '0;
                        entry_ms = e.duration;
                        play_pos = play_pos + 6'd1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.tone_freq = tone_now;
        r.playing = playing_now;
        return r;
    endfunction

    // Entry that the next tick would fetch but must not: never written, or too long to wait out.
    function automatic int stale_entry(input item_t w);
        logic [16:0] next_ms;
        logic [5:0]  at;
        if (w.cmd != CMD_TICK || !w.sound_on || !playing_now)
            return -1;
        next_ms = (elapsed_ms == ELAPSED_MAX) ? elapsed_ms : elapsed_ms + 17'd1;
        if (next_ms <= {1'b0, entry_ms})
            return -1;
        if (!tune_valid[play_pos])
            return int'(play_pos);
        at = play_pos;
        if (tune_mem[at].kind == KIND_LOOP)
            at = loop_addr;
        if (!tune_valid[at])
            return int'(at);
        if (!allow_long && tune_mem[at].kind < KIND_END && tune_mem[at].duration > 16'(LONG_MS))
            return int'(at);
        return -1;
    endfunction

    function automatic item_t rand_word();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(item_t)-1:0];
    endfunction

    function automatic item_t word_of(input logic [1:0] cmd, input logic [5:0] addr,
                                      input logic [3:0] note, input logic [5:0] semis,
                                      input logic [1:0] kind, input logic [15:0] ms,
                                      input logic snd);
        item_t w;
        w = '{cmd: cmd, address: addr, note: note, semitones: semis,
              kind: kind, duration_ms: ms, sound_on: snd};
        return w;
    endfunction

    function automatic result_t status_of(input logic [16:0] tone, input logic upd,
                                          input logic fin, input logic play);
        result_t r;
        r = '{tone_freq: tone, tone_update: upd, finished: fin, playing: play};
        return r;
    endfunction

    task automatic cmp_field(input string tag, input logic [16:0] want, input logic [16:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, tag, want, got);
            errors++;
        end
    endtask

    task automatic check_status(input result_t got);
        result_t want;
        if (status_due.size() == 0)
        begin
            $display("%0t ns: unexpected word, expected none, actual %p", $time, got);
            errors++;
            return;
        end
        want = status_due.pop_front();
        cmp_field("tone_freq", want.tone_freq, got.tone_freq);
        cmp_field("tone_update", 17'(want.tone_update), 17'(got.tone_update));
        cmp_field("finished", 17'(want.finished), 17'(got.finished));
        cmp_field("playing", 17'(want.playing), 17'(got.playing));
    endtask

    task automatic put_word(input item_t w, input bit typed, input result_t want);
        result_t r;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            items_if.valid <= 1'b0;
            @(posedge clk);
        end
        items_if.valid <= 1'b1;
        items_if.data <= w;
        @(posedge clk);
        while (!items_if.ready)
            @(posedge clk);
        r = player_step(w);
        status_due.push_back(typed ? want : r);
        words_sent++;
    endtask

    task automatic offer(input item_t w, input bit typed = 1'b0, input result_t want = NO_STATUS);
        int    gap;
        item_t fill;
        gap = stale_entry(w);
        while (gap >= 0)
        begin
            fill = rand_word();
            fill.cmd = CMD_WRITE;
            fill.address = 6'(gap);
            fill.duration_ms = 16'($urandom_range(0, 3));
            put_word(fill, 1'b0, NO_STATUS);
            gap = stale_entry(w);
        end
        put_word(w, typed, want);
    endtask

    task automatic wait_for_silence();
        items_if.valid <= 1'b0;
        while (status_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic play_random_tune();
        int         len;
        int         ticks;
        logic [5:0] base;
        item_t      w;
        len = $urandom_range(1, 8);
        base = 6'($urandom_range(0, 63));
        for (int i = 0; i < len; i++)
        begin
            w = rand_word();
            w.cmd = CMD_WRITE;
            w.address = base + 6'(i);
            w.kind = ($urandom_range(0, 9) < 7) ? KIND_TONE : KIND_REST;
            w.duration_ms = 16'($urandom_range(0, 3));
            offer(w);
        end
        w = rand_word();
        w.cmd = CMD_WRITE;
        w.address = base + 6'(len);
        w.kind = $urandom_range(0, 1) ? KIND_LOOP : KIND_END;
        offer(w);
        w = rand_word();
        w.cmd = CMD_START;
        w.address = base;
        offer(w);
        ticks = $urandom_range(len * 3, len * 8 + 4);
        for (int i = 0; i < ticks; i++)
        begin
            if ($urandom_range(0, 14) == 0)
                offer(rand_word());
            w = rand_word();
            w.cmd = CMD_TICK;
            w.sound_on = ($urandom_range(0, 39) != 0);
            offer(w);
        end
    endtask

    task automatic build_script();
        script.push_back('{word_of(CMD_TICK, 0, 0, 0, KIND_TONE, 0, 1), 1'b1, status_of(0, 0, 0, 0)});
        script.push_back('{word_of(CMD_UNUSED, 63, 15, 63, KIND_LOOP, 16'hFFFF, 1), 1'b1,
                           status_of(0, 0, 0, 0)});
        script.push_back('{word_of(CMD_TICK, 0, 0, 0, KIND_TONE, 0, 0), 1'b1, status_of(0, 1, 0, 0)});
        script.push_back('{word_of(CMD_WRITE, 0, 0, 0, KIND_TONE, 0, 0), 1'b1, status_of(0, 0, 0, 0)});
        script.push_back('{word_of(CMD_WRITE, 1, 15, 63, KIND_TONE, 1, 0), 1'b1, status_of(0, 0, 0, 0)});
        script.push_back('{word_of(CMD_WRITE, 2, 3, 5, KIND_REST, 0, 0), 1'b1, status_of(0, 0, 0, 0)});
        script.push_back('{word_of(CMD_WRITE, 3, 7, 9, KIND_LOOP, 16'hFFFF, 0), 1'b1,
                           status_of(0, 0, 0, 0)});
        script.push_back('{word_of(CMD_WRITE, 63, 9, 12, KIND_TONE, 2, 0), 1'b1, status_of(0, 0, 0, 0)});
        script.push_back('{word_of(CMD_START, 0, 0, 0, KIND_TONE, 0, 0), 1'b1, status_of(0, 0, 0, 1)});
        script.push_back('{word_of(CMD_TICK, 0, 0, 0, KIND_TONE, 0, 1), 1'b1, status_of(4186, 1, 0, 1)});
        script.push_back('{word_of(CMD_TICK, 0, 0, 0, KIND_TONE, 0, 1), 1'b0, NO_STATUS});
        script.push_back('{word_of(CMD_TICK, 0, 0, 0, KIND_TONE, 0, 1), 1'b0, NO_STATUS});
        script.push_back('{word_of(CMD_TICK, 0, 0, 0, KIND_TONE, 0, 1), 1'b1, status_of(0, 1, 0, 1)});
        script.push_back('{word_of(CMD_TICK, 0, 0, 0, KIND_TONE, 0, 1), 1'b1, status_of(4186, 1, 0, 1)});
        script.push_back('{word_of(CMD_TICK, 0, 0, 0, KIND_TONE, 0, 0), 1'b1, status_of(0, 1, 1, 0)});
        script.push_back('{word_of(CMD_START, 63, 0, 0, KIND_TONE, 0, 0), 1'b1, status_of(0, 0, 0, 1)});
        script.push_back('{word_of(CMD_TICK, 0, 0, 0, KIND_TONE, 0, 1), 1'b1,
                           status_of(14080, 1, 0, 1)});
        script.push_back('{word_of(CMD_TICK, 0, 0, 0, KIND_TONE, 0, 1), 1'b0, NO_STATUS});
        script.push_back('{word_of(CMD_TICK, 0, 0, 0, KIND_TONE, 0, 1), 1'b0, NO_STATUS});
        script.push_back('{word_of(CMD_TICK, 0, 0, 0, KIND_TONE, 0, 1), 1'b1, status_of(4186, 1, 0, 1)});
        script.push_back('{word_of(CMD_WRITE, 5, 0, 0, KIND_LOOP, 0, 0), 1'b0, NO_STATUS});
        script.push_back('{word_of(CMD_START, 5, 0, 0, KIND_TONE, 0, 0), 1'b0, NO_STATUS});
        script.push_back('{word_of(CMD_TICK, 0, 0, 0, KIND_TONE, 0, 1), 1'b1, status_of(0, 1, 1, 0)});
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            results_if.ready <= 1'b0;
        end
        else
        begin
            if (results_if.valid && results_if.ready)
                check_status(results_if.data);
            if (sink_hold_req > 0)
            begin
                hold_left = sink_hold_req;
                sink_hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                results_if.ready <= 1'b0;
            end
            else
            begin
                results_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int    phase_base;
        item_t w;
        rst_n = 1'b0;
        items_if.valid = 1'b0;
        items_if.data = '0;
        results_if.ready = 1'b0;
        play_pos = '0;
        loop_addr = '0;
        elapsed_ms = '0;
        entry_ms = '0;
        playing_now = 1'b0;
        tone_now = '0;
        allow_long = 1'b0;
        errors = 0;
        words_sent = 0;
        sink_hold_req = 0;
        hold_left = 0;
        src_idle_pct = 32;
        sink_stall_pct = 32;
        foreach (tune_valid[i])
            tune_valid[i] = 1'b0;
        build_script();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
            offer(script[i].w, script[i].typed, script[i].want);
        wait_for_silence();

        // Play a long entry, a short one after it, then the end.
        src_idle_pct = 0;
        sink_stall_pct = 0;
        allow_long = 1'b1;
        offer(word_of(CMD_WRITE, 10, 11, 47, KIND_TONE, 16'(LONG_RUN_MS), 1));
        offer(word_of(CMD_WRITE, 11, 4, 30, KIND_TONE, 16'd0, 1));
        offer(word_of(CMD_WRITE, 12, 7, 5, KIND_END, 16'h5A5A, 1));
        offer(word_of(CMD_START, 10, 0, 0, KIND_TONE, 0, 1));
        repeat (LONG_RUN_MS + 4)
        begin
            w = rand_word();
            w.cmd = CMD_TICK;
            w.sound_on = 1'b1;
            offer(w);
        end
        offer(word_of(CMD_WRITE, 12, 2, 7, KIND_TONE, 0, 1));
        offer(word_of(CMD_START, 12, 0, 0, KIND_TONE, 0, 1));
        offer(word_of(CMD_TICK, 0, 0, 0, KIND_TONE, 0, 1));
        allow_long = 1'b0;
        wait_for_silence();

        for (int ph = 0; ph < 4; ph++)
        begin
            src_idle_pct = src_plan[ph];
            sink_stall_pct = sink_plan[ph];
            if (ph == 0)
                sink_hold_req = 400;
            phase_base = words_sent;
            while (words_sent - phase_base < PHASE_WORDS)
                play_random_tune();
            wait_for_silence();
        end

        sink_stall_pct = 0;
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
